>>> hdl/bbpd_pkg.sv
// ----------------------------------------------------------------------------
// bbpd_pkg
// Shared types and constants of the button bitmap press debouncer.
// ----------------------------------------------------------------------------
package bbpd_pkg;

    localparam int NUM_BUTTONS_DEF = 32;
    localparam int IDX_W           = 5;
    localparam int TIME_W          = 32;
    localparam int MAP_W           = 32;
    localparam int DEB_W           = 16;
    localparam int CFG_IDX_W       = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL = CFG_IDX_W'(1);

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(300);
    localparam logic             LEVEL_RESET    = 1'b0;

    typedef struct packed {
        logic [MAP_W-1:0]  buttons;
        logic [TIME_W-1:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] button_index;
        logic             is_last;
    } result_t;

    // Request from the scan sequencer to the press time memory
    typedef struct packed {
        logic              re;
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [TIME_W-1:0] wdata;
    } mem_req_t;

endpackage

>>> hdl/button_bitmap_press_debouncer_unit.sv
// ----------------------------------------------------------------------------
// button_bitmap_press_debouncer_unit
// Per-button press edge detect with lockout debounce over a 32-bit bitmap.
// ----------------------------------------------------------------------------
// The sequencer visits one button per cycle when it is not held in a compare
// step; each bit that changed to the pressed level adds a compare step,
// because the last press time comes from a single-port memory with
// registered read data before the shared subtract/compare unit sees it. A
// stalled result port holds the sequencer in the compare step or at the
// finish. Results come out in ascending button order, the final one of an
// item carrying is_last; an item that yields no press gives no result.
// item_ready is high only between items. There is no clearing pass after
// reset; valid bits make untouched press times read as zero.
// ----------------------------------------------------------------------------
module button_bitmap_press_debouncer_unit
    import bbpd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DEB_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    logic [DEB_W-1:0]  debounce_ms_reg;
    logic              pressed_level_reg;
    mem_req_t          mem_req;
    logic [TIME_W-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= DEBOUNCE_RESET;
            pressed_level_reg <= LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data;
                REG_PRESSED_LEVEL: pressed_level_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    bbpd_scan_seq #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_scan_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .debounce_ms   (debounce_ms_reg),
        .pressed_level (pressed_level_reg),
        .mem_req       (mem_req),
        .rd_data       (rd_data)
    );

    bbpd_time_mem #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_time_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

>>> hdl/bbpd_time_mem.sv
// ----------------------------------------------------------------------------
// bbpd_time_mem
// Per-button last press time store, one port, registered read data.
// ----------------------------------------------------------------------------
module bbpd_time_mem
    import bbpd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          mem_req,
    output logic [TIME_W-1:0] rd_data
);

    localparam int AW    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int DEPTH = 2 ** AW;

    logic [TIME_W-1:0] time_mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [TIME_W-1:0] rd_data_reg;
    logic [AW-1:0]     addr;

    assign addr = mem_req.addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            time_mem[addr] <= mem_req.wdata;
        end
        // An entry never written reads as the reset time of zero
        if (mem_req.re)
        begin
            rd_data_reg <= valid_reg[addr] ? time_mem[addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_req.we)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/bbpd_scan_seq.sv
// ----------------------------------------------------------------------------
// bbpd_scan_seq
// Scan sequencer: walks the changed bits, checks lockout with one shared
// subtract/compare unit, and emits results through a one-deep hold stage.
// ----------------------------------------------------------------------------
module bbpd_scan_seq
    import bbpd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic [DEB_W-1:0]  debounce_ms,
    input  logic              pressed_level,
    output mem_req_t          mem_req,
    input  logic [TIME_W-1:0] rd_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMP   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [MAP_W-1:0]  prev_reg, prev_next;
    logic [MAP_W-1:0]  bitmap_reg, bitmap_next;
    logic [MAP_W-1:0]  changed_reg, changed_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic              cand;
    logic              at_end;
    logic              out_free;
    logic [TIME_W-1:0] elapsed;
    logic              pass;

    assign cand     = changed_reg[idx_reg] && (bitmap_reg[idx_reg] == pressed_level);
    assign at_end   = (idx_reg == LAST_IDX);
    assign out_free = !result_valid_reg || result_ready;
    assign elapsed  = now_reg - rd_data;
    assign pass     = (elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms});

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        prev_next         = prev_reg;
        bitmap_next       = bitmap_reg;
        changed_next      = changed_reg;
        now_next          = now_reg;
        pend_valid_next   = pend_valid_reg;
        pend_idx_next     = pend_idx_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        mem_req           = '0;

        // Drop the output item once taken; a load below overrides this
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    bitmap_next  = item.buttons;
                    now_next     = item.time_ms;
                    changed_next = item.buttons ^ prev_reg;
                    prev_next    = item.buttons;
                    idx_next     = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cand)
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = idx_reg;
                    state_next   = ST_COMP;
                end
                else if (at_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_COMP:
            begin
                if (!pass || !pend_valid_reg || out_free)
                begin
                    if (pass)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = idx_reg;
                        mem_req.wdata = now_reg;
                        // A later press exists, so the held one is not last
                        if (pend_valid_reg)
                        begin
                            result_valid_next        = 1'b1;
                            result_next.button_index = pend_idx_reg;
                            result_next.is_last      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                    end
                    if (at_end)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    result_valid_next        = 1'b1;
                    result_next.button_index = pend_idx_reg;
                    result_next.is_last      = 1'b1;
                    pend_valid_next          = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            prev_reg         <= '1;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            prev_reg         <= prev_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bitmap_reg   <= bitmap_next;
        changed_reg  <= changed_next;
        now_reg      <= now_next;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // No held press survives the end of a scan
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("held press left over after scan");

    // Press times are only written in the compare state
    a_write_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> state_reg == ST_COMP && pend_valid_next)
        else $error("press time written outside compare");

    // Scan index stays within the button range
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("scan index out of range");

    // A compare always follows a read of the same entry
    a_comp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.re |=> state_reg == ST_COMP && $stable(idx_reg))
        else $error("compare not aligned with memory read");

endmodule
